// ===== hdl/grg_pkg.sv =====
package grg_pkg;

  localparam int unsigned LOG_FRAC   = 30;
  localparam int unsigned X_QW       = 33;
  localparam int unsigned MAG_W      = 36;
  localparam int unsigned A_QW       = 38;
  localparam int unsigned A_DW       = 48;
  localparam int unsigned Y_W        = 33;
  localparam int unsigned GAMMA_W    = 14;
  localparam int unsigned BRIGHT_W   = 13;
  localparam int unsigned CONTRAST_W = 14;
  localparam int unsigned APB_AW     = 4;

  localparam logic [GAMMA_W-1:0]           GAMMA_LO      = 14'd1229;
  localparam logic [GAMMA_W-1:0]           GAMMA_HI      = 14'd12288;
  localparam logic [GAMMA_W-1:0]           GAMMA_RST     = 14'd4096;
  localparam logic [CONTRAST_W-1:0]        CONTRAST_LO   = 14'd1229;
  localparam logic [CONTRAST_W-1:0]        CONTRAST_HI   = 14'd8192;
  localparam logic [CONTRAST_W-1:0]        CONTRAST_RST  = 14'd4096;
  localparam logic signed [BRIGHT_W-1:0]   BRIGHT_LO     = -13'sd2048;
  localparam logic signed [BRIGHT_W-1:0]   BRIGHT_HI     = 13'sd2048;
  localparam logic [BRIGHT_W-1:0]          BRIGHT_RST    = 13'd0;

  typedef enum logic [1:0] {
    REG_GAMMA    = 2'd0,
    REG_BRIGHT   = 2'd1,
    REG_CONTRAST = 2'd2
  } reg_idx_e;

  // floor square root, elaboration use only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] val;
    logic [63:0] res;
    logic [63:0] bm;
    val = v;
    res = '0;
    bm  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (val >= res + bm) begin
        val = val - (res + bm);
        res = (res >> 1) + bm;
      end else begin
        res = res >> 1;
      end
      bm = bm >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-(j+1)) in q0.32
  function automatic logic [31:0] exp_factor(input int unsigned j);
    logic [63:0] r;
    r = isqrt64(64'h8000_0000_0000_0000);
    for (int unsigned k = 0; k < j; k++) begin
      r = isqrt64({r[31:0], 32'h0});
    end
    return r[31:0];
  endfunction

endpackage

// ===== hdl/grg_div_pipe.sv =====
module grg_div_pipe #(
  parameter int unsigned DVW = 14,
  parameter int unsigned QW  = 38,
  parameter int unsigned SW  = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [DVW-1:0] rem_i,
  input  logic [QW-1:0]  low_i,
  input  logic [DVW-1:0] div_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [QW-1:0]  quo_o,
  output logic [SW-1:0]  side_o
);

  logic           valid_q [QW];
  logic [DVW-1:0] rem_q   [QW];
  logic [QW-1:0]  low_q   [QW];
  logic [SW-1:0]  side_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic           valid_in;
    logic [DVW-1:0] rem_in;
    logic [QW-1:0]  low_in;
    logic [SW-1:0]  side_in;
    logic [DVW:0]   trial;
    logic [DVW:0]   diff;
    logic           take;

    if (k == 0) begin : g_head
      assign valid_in = valid_i;
      assign rem_in   = rem_i;
      assign low_in   = low_i;
      assign side_in  = side_i;
    end else begin : g_body
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign low_in   = low_q[k-1];
      assign side_in  = side_q[k-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign take  = trial >= {1'b0, div_i};
    assign diff  = trial - {1'b0, div_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? diff[DVW-1:0] : trial[DVW-1:0];
      low_q[k]  <= {low_in[QW-2:0], take};
      side_q[k] <= side_in;
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quo_o   = low_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== hdl/grg_log2_pipe.sv =====
module grg_log2_pipe
  import grg_pkg::*;
#(
  parameter int unsigned SW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [31:0]      x_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [MAG_W-1:0] mag_o,
  output logic [SW-1:0]    side_o
);

  logic [4:0]  pos_d;
  logic        enc_valid_q;
  logic [31:0] enc_x_q;
  logic [4:0]  enc_pos_q;
  logic [SW-1:0] enc_side_q;
  logic        nrm_valid_q;
  logic [31:0] nrm_m_q;
  logic [4:0]  nrm_pos_q;
  logic [SW-1:0] nrm_side_q;

  logic                sq_valid_q [LOG_FRAC];
  logic [31:0]         sq_m_q     [LOG_FRAC];
  logic [LOG_FRAC-1:0] sq_f_q     [LOG_FRAC];
  logic [4:0]          sq_pos_q   [LOG_FRAC];
  logic [SW-1:0]       sq_side_q  [LOG_FRAC];

  logic [MAG_W-1:0] mag_d;
  logic             mag_valid_q;
  logic [MAG_W-1:0] mag_q;
  logic [SW-1:0]    mag_side_q;

  // leading one
  always_comb begin
    pos_d = '0;
    for (int i = 1; i < 32; i++) begin
      if (x_i[i]) begin
        pos_d = 5'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_valid_q <= 1'b0;
      nrm_valid_q <= 1'b0;
      mag_valid_q <= 1'b0;
    end else begin
      enc_valid_q <= valid_i;
      nrm_valid_q <= enc_valid_q;
      mag_valid_q <= sq_valid_q[LOG_FRAC-1];
    end
  end

  always_ff @(posedge clk_i) begin
    enc_x_q    <= x_i;
    enc_pos_q  <= pos_d;
    enc_side_q <= side_i;
    nrm_m_q    <= enc_x_q << (5'd31 - enc_pos_q);
    nrm_pos_q  <= enc_pos_q;
    nrm_side_q <= enc_side_q;
  end

  for (genvar j = 0; j < LOG_FRAC; j++) begin : g_sq
    logic                valid_in;
    logic [31:0]         m_in;
    logic [LOG_FRAC-1:0] f_in;
    logic [4:0]          pos_in;
    logic [SW-1:0]       side_in;
    logic [63:0]         prod;
    logic [32:0]         sq;

    if (j == 0) begin : g_head
      assign valid_in = nrm_valid_q;
      assign m_in     = nrm_m_q;
      assign f_in     = '0;
      assign pos_in   = nrm_pos_q;
      assign side_in  = nrm_side_q;
    end else begin : g_body
      assign valid_in = sq_valid_q[j-1];
      assign m_in     = sq_m_q[j-1];
      assign f_in     = sq_f_q[j-1];
      assign pos_in   = sq_pos_q[j-1];
      assign side_in  = sq_side_q[j-1];
    end

    assign prod = m_in * m_in;
    assign sq   = prod[63:31];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_valid_q[j] <= 1'b0;
      end else begin
        sq_valid_q[j] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_m_q[j]    <= sq[32] ? sq[32:1] : sq[31:0];
      sq_f_q[j]    <= {f_in[LOG_FRAC-2:0], sq[32]};
      sq_pos_q[j]  <= pos_in;
      sq_side_q[j] <= side_in;
    end
  end

  assign mag_d = {6'(6'd32 - {1'b0, sq_pos_q[LOG_FRAC-1]}), {LOG_FRAC{1'b0}}}
               - {6'b0, sq_f_q[LOG_FRAC-1]};

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    mag_side_q <= sq_side_q[LOG_FRAC-1];
  end

  assign valid_o = mag_valid_q;
  assign mag_o   = mag_q;
  assign side_o  = mag_side_q;

endmodule

// ===== hdl/grg_exp2_pipe.sv =====
module grg_exp2_pipe
  import grg_pkg::*;
#(
  parameter int unsigned SW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [A_QW-1:0] a_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [Y_W-1:0]  y_o,
  output logic [SW-1:0]   side_o
);

  logic                st_valid_q [LOG_FRAC];
  logic [Y_W-1:0]      st_y_q     [LOG_FRAC];
  logic [LOG_FRAC-1:0] st_frac_q  [LOG_FRAC];
  logic                st_zero_q  [LOG_FRAC];
  logic [4:0]          st_sh_q    [LOG_FRAC];
  logic [SW-1:0]       st_side_q  [LOG_FRAC];

  logic           out_valid_q;
  logic [Y_W-1:0] out_y_q;
  logic [SW-1:0]  out_side_q;

  for (genvar j = 0; j < LOG_FRAC; j++) begin : g_mul
    localparam logic [31:0] FACTOR = exp_factor(j);
    logic                valid_in;
    logic [Y_W-1:0]      y_in;
    logic [LOG_FRAC-1:0] frac_in;
    logic                zero_in;
    logic [4:0]          sh_in;
    logic [SW-1:0]       side_in;
    logic [Y_W+31:0]     prod;

    if (j == 0) begin : g_head
      assign valid_in = valid_i;
      assign y_in     = {1'b1, 32'h0};
      assign frac_in  = a_i[LOG_FRAC-1:0];
      assign zero_in  = |a_i[A_QW-1:LOG_FRAC+5];
      assign sh_in    = a_i[LOG_FRAC+4:LOG_FRAC];
      assign side_in  = side_i;
    end else begin : g_body
      assign valid_in = st_valid_q[j-1];
      assign y_in     = st_y_q[j-1];
      assign frac_in  = st_frac_q[j-1];
      assign zero_in  = st_zero_q[j-1];
      assign sh_in    = st_sh_q[j-1];
      assign side_in  = st_side_q[j-1];
    end

    assign prod = y_in * FACTOR;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_valid_q[j] <= 1'b0;
      end else begin
        st_valid_q[j] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      st_y_q[j]    <= frac_in[LOG_FRAC-1-j] ? prod[Y_W+31:32] : y_in;
      st_frac_q[j] <= frac_in;
      st_zero_q[j] <= zero_in;
      st_sh_q[j]   <= sh_in;
      st_side_q[j] <= side_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= st_valid_q[LOG_FRAC-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_y_q    <= st_zero_q[LOG_FRAC-1] ? '0
                : (st_y_q[LOG_FRAC-1] >> st_sh_q[LOG_FRAC-1]);
    out_side_q <= st_side_q[LOG_FRAC-1];
  end

  assign valid_o = out_valid_q;
  assign y_o     = out_y_q;
  assign side_o  = out_side_q;

endmodule

// ===== hdl/gamma_ramp_generator_top.sv =====
// channel  | direction | beat marked by                     | payload
// item in  | in        | start high while busy low          | code_value_i
// result   | out       | result_valid_o, one cycle, no hold | entry_index_o, ramp_level_o
// config   | in        | psel & penable & pwrite            | paddr (3:2 selects), pwdata
//
// one beat accepted per cycle; busy stays low
// results pass through the reciprocal divide by 2^INDEX_BITS-1, log2 squaring chain,
// divider by gamma and exp2 product chain, plus code stages and boundary registers
// reset clears all valid bits and loads default registers; no clearing pass
// the pipeline never stalls since the receiver cannot hold results off
module gamma_ramp_generator_top
  import grg_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 8,
  parameter int unsigned LEVEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [INDEX_BITS-1:0] code_value_i,
  output logic                  result_valid_o,
  output logic [INDEX_BITS-1:0] entry_index_o,
  output logic [LEVEL_BITS-1:0] ramp_level_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned NUM_W = INDEX_BITS + 13;
  localparam int unsigned SUM_W = INDEX_BITS + 18;
  localparam int unsigned SCL_W = LEVEL_BITS + 33;
  localparam logic [INDEX_BITS-1:0] MAX_CODE = '1;
  localparam logic [LEVEL_BITS-1:0] MAX_LEVEL = '1;
  localparam logic [NUM_W-1:0] DEN = {MAX_CODE, 13'b0};
  localparam int unsigned QA_W  = 14;
  localparam int unsigned FB_W  = X_QW - QA_W;
  localparam int unsigned RA_W  = INDEX_BITS + 14;
  localparam int unsigned RB_W  = INDEX_BITS + 20;
  localparam int unsigned NB_W  = INDEX_BITS + FB_W;
  localparam int unsigned PA_W  = NUM_W + RA_W;
  localparam int unsigned PB_W  = NB_W + RB_W;
  localparam int unsigned SH_A  = 2 * INDEX_BITS + 13;
  localparam int unsigned SH_B  = 2 * INDEX_BITS + FB_W;
  localparam logic [RA_W-1:0] RECIP_A =
    RA_W'(((64'd1 << SH_A) + 64'(MAX_CODE) - 64'd1) / 64'(MAX_CODE));
  localparam logic [RB_W-1:0] RECIP_B =
    RB_W'(((64'd1 << SH_B) + 64'(MAX_CODE) - 64'd1) / 64'(MAX_CODE));
  localparam logic [FB_W-1:0] HALF_CODE = FB_W'(MAX_CODE >> 1);

  logic [GAMMA_W-1:0]    gamma_q;
  logic [BRIGHT_W-1:0]   bright_q;
  logic [CONTRAST_W-1:0] contrast_q;

  logic [GAMMA_W-1:0]         gamma_c;
  logic [CONTRAST_W-1:0]      contrast_c;
  logic signed [BRIGHT_W-1:0] bright_c;
  logic signed [14:0]         bscale_s;

  logic                       s1_valid_q;
  logic [INDEX_BITS-1:0]      s1_code_q;
  logic signed [INDEX_BITS+1:0]  diff_d;
  logic signed [INDEX_BITS+16:0] prod_d;
  logic [INDEX_BITS+13:0]        off_d;
  logic                          s2_valid_q;
  logic [INDEX_BITS-1:0]         s2_code_q;
  logic signed [INDEX_BITS+16:0] s2_prod_q;
  logic [INDEX_BITS+13:0]        s2_off_q;
  logic signed [SUM_W-1:0]       sum_d;
  logic [NUM_W-1:0]              num_d;
  logic                          s3_valid_q;
  logic [INDEX_BITS-1:0]         s3_code_q;
  logic [NUM_W-1:0]              s3_num_q;

  logic [PA_W-1:0]       prod_a_d;
  logic                  xa_valid_q;
  logic [INDEX_BITS-1:0] xa_code_q;
  logic [NUM_W-1:0]      xa_num_q;
  logic [PA_W-1:0]       xa_prod_q;
  logic [QA_W-1:0]       quo_a_d;
  logic [NUM_W:0]        qm_d;
  logic [NUM_W:0]        rem_a_d;
  logic                  xb_valid_q;
  logic [INDEX_BITS-1:0] xb_code_q;
  logic [QA_W-1:0]       xb_quo_q;
  logic [NB_W-1:0]       xb_nb_q;
  logic [PB_W-1:0]       prod_b_d;
  logic                  xc_valid_q;
  logic [INDEX_BITS-1:0] xc_code_q;
  logic [QA_W-1:0]       xc_quo_q;
  logic [PB_W-1:0]       xc_prod_q;

  logic                  x_valid;
  logic [X_QW-1:0]       x_quo;
  logic [INDEX_BITS-1:0] x_code;

  logic                    l_valid;
  logic [MAG_W-1:0]        l_mag;
  logic [INDEX_BITS+1:0]   l_side;
  logic [A_DW-1:0]         adiv;
  logic                    a_valid;
  logic [A_QW-1:0]         a_quo;
  logic [INDEX_BITS+1:0]   a_side;
  logic                    e_valid;
  logic [Y_W-1:0]          e_y;
  logic [INDEX_BITS+1:0]   e_side;

  logic [SCL_W-1:0]      scaled;
  logic [LEVEL_BITS:0]   rounded;
  logic [LEVEL_BITS-1:0] level_d;
  logic                  res_valid_q;
  logic [INDEX_BITS-1:0] res_index_q;
  logic [LEVEL_BITS-1:0] res_level_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q    <= GAMMA_RST;
      bright_q   <= BRIGHT_RST;
      contrast_q <= CONTRAST_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_GAMMA:    gamma_q    <= pwdata[GAMMA_W-1:0];
        REG_BRIGHT:   bright_q   <= pwdata[BRIGHT_W-1:0];
        REG_CONTRAST: contrast_q <= pwdata[CONTRAST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GAMMA:    prdata = {18'b0, gamma_q};
      REG_BRIGHT:   prdata = {19'b0, bright_q};
      REG_CONTRAST: prdata = {18'b0, contrast_q};
      default:      prdata = '0;
    endcase
  end

  // saturation to the legal ranges
  always_comb begin
    if (gamma_q < GAMMA_LO) begin
      gamma_c = GAMMA_LO;
    end else if (gamma_q > GAMMA_HI) begin
      gamma_c = GAMMA_HI;
    end else begin
      gamma_c = gamma_q;
    end
    if (contrast_q < CONTRAST_LO) begin
      contrast_c = CONTRAST_LO;
    end else if (contrast_q > CONTRAST_HI) begin
      contrast_c = CONTRAST_HI;
    end else begin
      contrast_c = contrast_q;
    end
    if ($signed(bright_q) < BRIGHT_LO) begin
      bright_c = BRIGHT_LO;
    end else if ($signed(bright_q) > BRIGHT_HI) begin
      bright_c = BRIGHT_HI;
    end else begin
      bright_c = $signed(bright_q);
    end
  end

  // 4096 + 2*brightness, never negative
  assign bscale_s = 15'sd4096 + 15'($signed({bright_c, 1'b0}));

  assign diff_d = $signed({1'b0, s1_code_q, 1'b0}) - $signed({2'b00, MAX_CODE});
  assign prod_d = diff_d * $signed({1'b0, contrast_c});
  assign off_d  = {14'b0, MAX_CODE} * {{INDEX_BITS{1'b0}}, bscale_s[13:0]};
  assign sum_d  = SUM_W'(s2_prod_q) + $signed({4'b0, s2_off_q});

  always_comb begin
    if (sum_d[SUM_W-1]) begin
      num_d = '0;
    end else if (sum_d > $signed({5'b0, DEN})) begin
      num_d = DEN;
    end else begin
      num_d = sum_d[NUM_W-1:0];
    end
  end

  // x = round(num / den) in q1.32: quotient and remainder by m, then remainder scaled
  assign prod_a_d = PA_W'(s3_num_q) * PA_W'(RECIP_A);
  assign quo_a_d  = xa_prod_q[SH_A +: QA_W];
  assign qm_d     = {quo_a_d, {INDEX_BITS{1'b0}}} - {{INDEX_BITS{1'b0}}, quo_a_d};
  assign rem_a_d  = {1'b0, xa_num_q} - qm_d;
  assign prod_b_d = PB_W'(xb_nb_q) * PB_W'(RECIP_B);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      xa_valid_q <= 1'b0;
      xb_valid_q <= 1'b0;
      xc_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      xa_valid_q <= s3_valid_q;
      xb_valid_q <= xa_valid_q;
      xc_valid_q <= xb_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_code_q <= code_value_i;
    s2_code_q <= s1_code_q;
    s2_prod_q <= prod_d;
    s2_off_q  <= off_d;
    s3_code_q <= s2_code_q;
    s3_num_q  <= num_d;
    xa_code_q <= s3_code_q;
    xa_num_q  <= s3_num_q;
    xa_prod_q <= prod_a_d;
    xb_code_q <= xa_code_q;
    xb_quo_q  <= quo_a_d;
    xb_nb_q   <= {rem_a_d[INDEX_BITS-1:0], HALF_CODE};
    xc_code_q <= xb_code_q;
    xc_quo_q  <= xb_quo_q;
    xc_prod_q <= prod_b_d;
  end

  assign x_valid = xc_valid_q;
  assign x_quo   = {xc_quo_q, xc_prod_q[SH_B +: FB_W]};
  assign x_code  = xc_code_q;

  grg_log2_pipe #(
    .SW(INDEX_BITS + 2)
  ) u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(x_valid),
    .x_i    (x_quo[31:0]),
    .side_i ({x_quo == '0, x_quo[32], x_code}),
    .valid_o(l_valid),
    .mag_o  (l_mag),
    .side_o (l_side)
  );

  assign adiv = {l_mag, 12'b0} + {35'b0, gamma_c[GAMMA_W-1:1]};

  grg_div_pipe #(
    .DVW(GAMMA_W),
    .QW (A_QW),
    .SW (INDEX_BITS + 2)
  ) u_adiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(l_valid),
    .rem_i  ({4'b0, adiv[A_DW-1:A_QW]}),
    .low_i  (adiv[A_QW-1:0]),
    .div_i  (gamma_c),
    .side_i (l_side),
    .valid_o(a_valid),
    .quo_o  (a_quo),
    .side_o (a_side)
  );

  grg_exp2_pipe #(
    .SW(INDEX_BITS + 2)
  ) u_exp2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(a_valid),
    .a_i    (a_quo),
    .side_i (a_side),
    .valid_o(e_valid),
    .y_o    (e_y),
    .side_o (e_side)
  );

  assign scaled  = {{LEVEL_BITS{1'b0}}, e_y} * {33'b0, MAX_LEVEL}
                 + {{(LEVEL_BITS + 1){1'b0}}, 1'b1, 31'b0};
  assign rounded = scaled[SCL_W-1:32];

  always_comb begin
    if (e_side[INDEX_BITS+1]) begin
      level_d = '0;
    end else if (e_side[INDEX_BITS] || (rounded > {1'b0, MAX_LEVEL})) begin
      level_d = MAX_LEVEL;
    end else begin
      level_d = rounded[LEVEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= e_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_index_q <= e_side[INDEX_BITS-1:0];
    res_level_q <= level_d;
  end

  assign result_valid_o = res_valid_q;
  assign entry_index_o  = res_index_q;
  assign ramp_level_o   = res_level_q;

`ifndef SYNTH
  localparam int unsigned LATENCY = 3 + 3 + 2 + LOG_FRAC + 1 + A_QW + LOG_FRAC + 2;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY result_valid_o)
    else $error("accepted beat did not come out on time");

  a_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without a matching start beat");

  a_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (entry_index_o == $past(code_value_i, LATENCY)))
    else $error("entry index does not match its start beat");
`endif

endmodule
